/* sv/lmsb_pkg.sv */
// Shared constants, types and helpers for the LED matrix scan buffer.
package lmsb_pkg;

  localparam int MAX_WIDTH       = 64;
  localparam int MAX_HEIGHT      = 64;
  localparam int MAX_FRAME_BYTES = 16;

  localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;
  localparam int WORD_BYTES    = 8;
  localparam int WORD_W        = WORD_BYTES * 8;
  localparam int STORE_WORDS   = STORE_BYTES / WORD_BYTES;

  localparam int ADDR_W    = $clog2(STORE_BYTES);
  localparam int WADDR_W   = $clog2(STORE_WORDS);
  localparam int BSEL_W    = $clog2(WORD_BYTES);
  localparam int ROWB_W    = $clog2(ROW_BYTES_MAX + 1);
  localparam int FBYTES_W  = 5;
  localparam int FIDX_W    = $clog2(MAX_FRAME_BYTES);
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 6;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHOW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 2'd2;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_SHOW  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_ERR   = 2'd3
  } op_t;

  // Classified command: addr is the pixel byte for a set, the row base for a show.
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [2:0]          bitn;
    logic                on;
    logic [ROWB_W-1:0]   rowbytes;
    logic [FBYTES_W-1:0] nbytes;
    logic [FIDX_W-1:0]   selbyte;
  } cmd_t;

  typedef struct packed {
    logic       idle;
    logic [1:0] ofifo_level;
  } bk_stat_t;

  typedef struct packed {
    logic [1:0] level;
  } q_stat_t;

  // Saturate a register value into 1..hi.
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/lmsb_front.sv */
// Front end: configuration registers, command decode and range checks.
module lmsb_front import lmsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,
  input  logic [KIND_W-1:0]    s_axis_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  localparam int PW = ADDR_W + 1;

  logic [CFG_W-1:0]    row_width;
  logic [CFG_W-1:0]    row_count;
  logic [FBYTES_W-1:0] frame_bytes;

  logic [COORD_W-1:0]  x;
  logic [COORD_W-1:0]  y;
  logic                on;
  logic [CFG_W:0]      rw_round;
  logic [ROWB_W-1:0]   rowbytes;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       set_idx;
  logic [FBYTES_W-1:0] yrow;
  logic                err_set;
  logic                err_show;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= CFG_W'(MAX_WIDTH);
      row_count   <= CFG_W'(MAX_HEIGHT);
      frame_bytes <= FBYTES_W'(MAX_FRAME_BYTES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:   row_width <= clamp_cfg(cfg_data, CFG_W'(MAX_WIDTH));
        REG_ROW_COUNT:   row_count <= clamp_cfg(cfg_data, CFG_W'(MAX_HEIGHT));
        REG_FRAME_BYTES: frame_bytes <= FBYTES_W'(clamp_cfg(
                             {{(CFG_W-FBYTES_W){1'b0}}, cfg_data[FBYTES_W-1:0]},
                             CFG_W'(MAX_FRAME_BYTES)));
        default: ;
      endcase
    end
  end

  assign x  = s_axis_tdata[5:0];
  assign y  = s_axis_tdata[11:6];
  assign on = s_axis_tdata[12];

  assign rw_round = {1'b0, row_width} + (CFG_W+1)'(7);
  assign rowbytes = rw_round[ROWB_W+2:3];
  assign prod     = PW'(rowbytes) * PW'(y);
  assign set_idx  = prod + PW'(rowbytes) - PW'(x[5:3]) - PW'(1);
  assign yrow     = FBYTES_W'(y[5:3]) + FBYTES_W'(1);

  assign err_set  = (CFG_W'(x) >= row_width) || (CFG_W'(y) >= row_count);
  assign err_show = (CFG_W'(y) >= row_count) ||
                    (frame_bytes < FBYTES_W'(rowbytes)) ||
                    (frame_bytes < yrow);

  always_comb begin
    cmd          = '0;
    cmd.rowbytes = rowbytes;
    cmd.nbytes   = frame_bytes;
    cmd.selbyte  = FIDX_W'(frame_bytes - yrow);
    cmd.on       = on;
    cmd_valid    = s_axis_tvalid;
    unique case (s_axis_tuser)
      KIND_SET: begin
        cmd.op   = err_set ? OP_ERR : OP_SET;
        cmd.addr = set_idx[ADDR_W-1:0];
        cmd.bitn = x[2:0];
      end
      KIND_SHOW: begin
        cmd.op   = err_show ? OP_ERR : OP_SHOW;
        cmd.addr = prod[ADDR_W-1:0];
        cmd.bitn = y[2:0];
      end
      KIND_CLEAR: cmd.op = OP_CLEAR;
      default: cmd_valid = 1'b0;  // unused kind: take it and drop it
    endcase
  end

  assign s_axis_tready = cmd_ready;

endmodule

/* sv/lmsb_cmd_queue.sv */
// Two-entry command queue between front end and back end.
module lmsb_cmd_queue import lmsb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  cmd_t    push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output cmd_t    pop_data,
  output q_stat_t stat
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] level;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (level != 2'd2);
  assign pop_valid  = (level != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rptr];
  assign stat.level = level;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      level <= level + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* sv/lmsb_back.sv */
// Back end: pixel store, command sequencer, read stage and output queue.
module lmsb_back import lmsb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,
  output bk_stat_t   stat
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHOW  = 3'b010,
    ST_SETWR = 3'b100
  } state_t;

  typedef struct packed {
    logic               is_data;
    logic               is_sel;
    logic [2:0]         selbit;
    logic               last;
    logic               err;
    logic [WADDR_W-1:0] waddr;
    logic [BSEL_W-1:0]  bsel;
  } stg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } out_t;

  state_t              state;
  state_t              state_next;
  cmd_t                cur;
  logic [FIDX_W-1:0]   cnt;
  logic [FIDX_W-1:0]   cnt_next;

  logic [WORD_W-1:0]   mem [STORE_WORDS];
  logic [WORD_W-1:0]   mem_q;
  logic [STORE_WORDS-1:0] row_valid;
  logic                rd_en;
  logic [WADDR_W-1:0]  rd_addr;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_data;
  logic [WORD_W-1:0]   set_word;
  logic                clear_all;

  logic                issue;
  stg_t                iss;
  stg_t                stg;
  logic                stg_valid;
  logic [ADDR_W-1:0]   byte_addr;
  logic [WORD_W-1:0]   stg_word;
  logic [7:0]          stg_byte;
  out_t                stg_out;

  out_t                ofifo [2];
  logic                owptr;
  logic                orptr;
  logic [1:0]          olevel;
  logic                opop;
  logic                can_issue;

  assign opop      = m_axis_tvalid && m_axis_tready;
  assign can_issue = ({1'b0, olevel} + 3'(stg_valid)) <= (3'd1 + 3'(opop));
  assign byte_addr = cur.addr + ADDR_W'(cnt);

  // Sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cmd.addr[ADDR_W-1:BSEL_W];
    wr_en      = 1'b0;
    clear_all  = 1'b0;
    issue      = 1'b0;
    iss        = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_SET: begin
              cmd_ready  = 1'b1;
              rd_en      = 1'b1;
              state_next = ST_SETWR;
            end
            OP_SHOW: begin
              cmd_ready  = 1'b1;
              cnt_next   = '0;
              state_next = ST_SHOW;
            end
            OP_CLEAR: begin
              cmd_ready = 1'b1;
              clear_all = 1'b1;
            end
            OP_ERR: begin
              if (can_issue) begin
                cmd_ready = 1'b1;
                issue     = 1'b1;
                iss.err   = 1'b1;
                iss.last  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHOW: begin
        if (can_issue) begin
          issue       = 1'b1;
          rd_en       = 1'b1;
          rd_addr     = byte_addr[ADDR_W-1:BSEL_W];
          iss.waddr   = byte_addr[ADDR_W-1:BSEL_W];
          iss.bsel    = byte_addr[BSEL_W-1:0];
          iss.is_data = (FIDX_W'(cur.rowbytes) > cnt);
          iss.is_sel  = (cnt == cur.selbyte);
          iss.selbit  = cur.bitn;
          iss.last    = ((FBYTES_W'(cnt) + FBYTES_W'(1)) == cur.nbytes);
          if (iss.last) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + FIDX_W'(1);
          end
        end
      end
      ST_SETWR: begin
        wr_en      = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stg_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stg_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    stg <= iss;
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
  end

  // Read-modify-write of one pixel bit; a word never written reads as all ones
  always_comb begin
    set_word = row_valid[cur.addr[ADDR_W-1:BSEL_W]] ? mem_q : '1;
    wr_data  = set_word;
    wr_data[{cur.addr[BSEL_W-1:0], cur.bitn}] = ~cur.on;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur.addr[ADDR_W-1:BSEL_W]] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[cur.addr[ADDR_W-1:BSEL_W]] <= 1'b1;
    end
  end

  // Read stage: pick the byte, fill past the row data, drop the select bit, zero an error
  always_comb begin
    stg_word = row_valid[stg.waddr] ? mem_q : '1;
    stg_byte = stg_word[{stg.bsel, 3'b000} +: 8];
    stg_out.data = stg.is_data ? stg_byte : 8'hff;
    if (stg.is_sel) begin
      stg_out.data = stg_out.data & ~(8'd1 << stg.selbit);
    end
    if (stg.err) begin
      stg_out.data = 8'h00;
    end
    stg_out.last = stg.last;
    stg_out.err  = stg.err;
  end

  // Output queue
  always_ff @(posedge clk) begin
    if (stg_valid) begin
      ofifo[owptr] <= stg_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      olevel <= 2'd0;
    end else begin
      if (stg_valid) owptr <= ~owptr;
      if (opop)      orptr <= ~orptr;
      olevel <= olevel + 2'(stg_valid) - 2'(opop);
    end
  end

  assign m_axis_tvalid    = (olevel != 2'd0);
  assign m_axis_tdata     = ofifo[orptr].data;
  assign m_axis_tlast     = ofifo[orptr].last;
  assign m_axis_tuser     = ofifo[orptr].err;
  assign stat.idle        = (state == ST_IDLE);
  assign stat.ofifo_level = olevel;

endmodule

/* sv/led_matrix_scan_buffer.sv */
// Top level of the LED matrix scan buffer: front end, command queue, back end.
//
// Framebuffer for an active-low multiplexed LED matrix, 64 x 64 pixels at most,
// held as 512 bytes in a 64-word by 64-bit store. Commands arrive on the slave
// stream with the kind in tuser: set writes one pixel bit (0 lights it), clear
// fills the store with ones, show streams one shift frame of frame_bytes bytes
// (row data, then 0xff fill, with the row-select bit cleared). A bad coordinate
// or a frame too short for the row gives a single result with tuser (error)
// and tlast high and data zero. In the back end, show takes the command, then reads
// one byte per cycle through the single store read port while the output queue has
// room, each byte passing the read stage and the output queue to the master stream;
// set reads the word, then writes it back; clear is done in the cycle it is taken;
// an error waits for output room. Clear resets all 64 word-valid flags together,
// so no sweep follows reset and commands are taken straight after it. A two-entry
// queue lets the front keep taking commands while a frame drains; a two-entry
// output queue holds the bytes in flight when the master stream stalls and keeps
// full rate while it is ready. Write configuration only while the block is idle;
// row width and row count saturate into 1..64, frame_bytes (data[4:0]) into 1..16.
module led_matrix_scan_buffer import lmsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,   // 0 row_width, 1 row_count, 2 frame_bytes
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // x_pos[5:0], y_pos[11:6], pixel_on[12]
  input  logic [KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // out_byte[7:0]
  output logic                 m_axis_tlast,  // last_byte
  output logic                 m_axis_tuser   // error
);

  logic     fq_valid;
  logic     fq_ready;
  cmd_t     fq_cmd;
  logic     qb_valid;
  logic     qb_ready;
  cmd_t     qb_cmd;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  // Decode and check commands against the live geometry
  lmsb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  // Decouple decode from execution
  lmsb_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_cmd),
    .stat       (q_stat)
  );

  // Execute against the store and stream frames out
  lmsb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (qb_valid),
    .cmd_ready     (qb_ready),
    .cmd           (qb_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .stat          (bk_stat)
  );

  // An error transfer is always a single, zero-valued, final result
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'h00)))
    else $error("error result without tlast or with nonzero data");

  // Output queue credit check must keep the level within its two entries
  a_ofifo_bound: assert property (@(posedge clk) disable iff (rst)
    bk_stat.ofifo_level != 2'd3)
    else $error("output queue overflow");

  // Command queue never holds more than two entries
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.level != 2'd3)
    else $error("command queue overflow");

  // Reset leaves the back end idle with nothing to transfer
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (bk_stat.idle && !m_axis_tvalid))
    else $error("back end not idle after reset");

endmodule
